// ----- hw/rtl/wpm_pkg.sv -----
// shared constants and types for the wildcard pattern matcher
// used by wpm_step and wildcard_pattern_match; no dependencies
`default_nettype none

package wpm_pkg;

    localparam int PAT_MAX   = 32;
    localparam int PAT_IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int PAT_LEN_W = $clog2(PAT_MAX + 1);
    localparam int POS_W     = PAT_MAX + 1;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_START  = 2'd2,
        KIND_TEXT   = 2'd3
    } kind_t;

    typedef logic [PAT_MAX-1:0][7:0] pat_store_t;
    typedef logic [POS_W-1:0]        pos_set_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wpm_step.sv -----
// one step of the active position set: seed position 0 on a start or advance over a text byte, then close over '*'
// depends on wpm_pkg
`default_nettype none

module wpm_step (
    input  wpm_pkg::kind_t                kind,
    input  logic [7:0]                    data_byte,
    input  wpm_pkg::pos_set_t             active,
    input  wpm_pkg::pat_store_t           pat_store,
    input  logic [wpm_pkg::PAT_LEN_W-1:0] pat_len,
    output wpm_pkg::pos_set_t             active_next,
    output logic                          matched
);

    logic [wpm_pkg::PAT_MAX-1:0] in_pat;
    logic [wpm_pkg::PAT_MAX-1:0] star_v;
    logic [wpm_pkg::PAT_MAX-1:0] step_v;
    logic [wpm_pkg::PAT_MAX-1:0] gen_v;
    wpm_pkg::pos_set_t           seed;
    wpm_pkg::pos_set_t           run_sum;
    wpm_pkg::pos_set_t           run_carry;

    always_comb
    begin
        for (int i = 0; i < wpm_pkg::PAT_MAX; i++)
        begin
            in_pat[i] = (wpm_pkg::PAT_LEN_W'(i) < pat_len);
            star_v[i] = in_pat[i] && (pat_store[i] == wpm_pkg::SYM_STAR);
            step_v[i] = in_pat[i] && ((pat_store[i] == wpm_pkg::SYM_STAR) ||
                                      (pat_store[i] == wpm_pkg::SYM_ANY) ||
                                      (pat_store[i] == data_byte));
        end
    end

    always_comb
    begin
        case (kind)
            wpm_pkg::KIND_START:
                seed = wpm_pkg::POS_W'(1);
            wpm_pkg::KIND_TEXT:
                // a star keeps its own position and every match moves one on
                seed = {1'b0, active[wpm_pkg::PAT_MAX-1:0] & star_v} |
                       {active[wpm_pkg::PAT_MAX-1:0] & step_v, 1'b0};
            default:
                seed = '0;
        endcase
    end

    // star closure as a carry chain: a set bit on a star run carries past the run's end
    assign gen_v       = seed[wpm_pkg::PAT_MAX-1:0] & star_v;
    assign run_sum     = {1'b0, star_v} + {1'b0, gen_v};
    assign run_carry   = run_sum ^ {1'b0, star_v} ^ {1'b0, gen_v};
    assign active_next = seed | run_carry;

    assign matched = ((kind == wpm_pkg::KIND_START) || (kind == wpm_pkg::KIND_TEXT)) &&
                     active_next[pat_len];

endmodule

`default_nettype wire

// ----- hw/rtl/wildcard_pattern_match.sv -----
// wildcard pattern matcher top level: input stage, pattern store, position set, result stage
// depends on wpm_pkg and wpm_step
//
// usage:
//   one input channel (item_valid, item_stall, kind, data_byte) and one result
//   channel (result_valid, result_stall, matched, status); a beat moves when
//   valid is high and stall is low at a rising edge of clk
//   kind 0 clears the pattern, kind 1 appends data_byte to it, kind 2 starts a
//   text, kind 3 feeds data_byte as the next text byte; every beat gives
//   exactly one result beat, in order
//   '?' in the pattern matches any one byte, '*' matches any run of bytes
//   the result is registered in the result stage when the input stage passes the beat on
//   throughput: one beat per cycle while the result is not stalled; the position
//   update (advance and star closure between the input stage and the result stage) is combinational
//   a stalled result holds; the input stage still takes one more beat and
//   item_stall rises only once both stages are full
//   reset (rst_n low, async) empties both stages, the pattern length and the
//   position set; pattern bytes themselves are not cleared
`default_nettype none

module wildcard_pattern_match (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_byte,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            status
);

    logic                          in_v_reg;
    logic                          in_v_next;
    wpm_pkg::kind_t                in_kind_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_v_reg;
    logic                          out_v_next;
    logic                          matched_reg;
    logic                          status_reg;
    logic [wpm_pkg::PAT_LEN_W-1:0] len_reg;
    logic [wpm_pkg::PAT_LEN_W-1:0] len_next;
    wpm_pkg::pos_set_t             active_reg;
    wpm_pkg::pos_set_t             active_next;
    wpm_pkg::pat_store_t           store_reg;

    wpm_pkg::pos_set_t             step_active;
    logic                          step_matched;
    logic                          out_free;
    logic                          fire;
    logic                          item_accept;
    logic                          pat_full;
    logic                          do_append;

    assign out_free    = !out_v_reg || !result_stall;
    assign fire        = in_v_reg && out_free;
    assign item_stall  = in_v_reg && !out_free;
    assign item_accept = item_valid && !item_stall;

    assign pat_full  = (len_reg == wpm_pkg::PAT_LEN_W'(wpm_pkg::PAT_MAX));
    assign do_append = fire && (in_kind_reg == wpm_pkg::KIND_APPEND) && !pat_full;

    wpm_step u_step (
        .kind        (in_kind_reg),
        .data_byte   (in_byte_reg),
        .active      (active_reg),
        .pat_store   (store_reg),
        .pat_len     (len_reg),
        .active_next (step_active),
        .matched     (step_matched)
    );

    always_comb
    begin
        in_v_next   = item_accept || (in_v_reg && !fire);
        out_v_next  = fire || (out_v_reg && result_stall);
        len_next    = len_reg;
        active_next = active_reg;
        if (fire)
        begin
            active_next = step_active;
            if (in_kind_reg == wpm_pkg::KIND_CLEAR)
            begin
                len_next = '0;
            end
            else if (do_append)
            begin
                len_next = len_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            len_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            in_v_reg   <= in_v_next;
            out_v_reg  <= out_v_next;
            len_reg    <= len_next;
            active_reg <= active_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            in_kind_reg <= wpm_pkg::kind_t'(kind);
            in_byte_reg <= data_byte;
        end
        if (fire)
        begin
            matched_reg <= step_matched;
            status_reg  <= (in_kind_reg == wpm_pkg::KIND_APPEND) && pat_full;
        end
        if (do_append)
        begin
            store_reg[len_reg[wpm_pkg::PAT_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign matched      = matched_reg;
    assign status       = status_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= wpm_pkg::PAT_LEN_W'(wpm_pkg::PAT_MAX))
        else $error("pattern length beyond capacity");

    a_no_pos_past_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((active_reg >> len_reg) >> 1) == '0)
        else $error("active position beyond pattern end");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_kind_reg == wpm_pkg::KIND_CLEAR)) |=>
            (len_reg == '0) && (active_reg == '0))
        else $error("clear left pattern or positions behind");

    a_status_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> !matched)
        else $error("dropped append reported a match");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_v_reg && out_v_reg))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// ----- tb/wildcard_pattern_match_test.sv -----
// self-checking testbench for wildcard_pattern_match: a directed table, then random
// pattern/text sequences and random beats checked against a predictor of the position set
// depends on wpm_pkg and the wildcard_pattern_match rtl

module wildcard_pattern_match_test;

    localparam int DIRECTED_COUNT = 23;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;

    typedef struct packed {
        logic matched;
        logic status;
    } match_result_t;

    typedef struct packed {
        wpm_pkg::kind_t kind_val;
        logic [7:0]     byte_val;
        logic           typed;
        match_result_t  res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       result_valid;
    logic       result_stall;
    logic       matched;
    logic       status;

    // predictor state
    logic [7:0]        pat_bytes [wpm_pkg::PAT_MAX];
    int unsigned       pat_len;
    wpm_pkg::pos_set_t reach;

    match_result_t pending_results [$];
    stim_row_t     directed_rows [DIRECTED_COUNT];

    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned match_count;
    int unsigned drop_count;
    int unsigned error_count;
    int unsigned idle_cycles;
    bit          quiet;

    wildcard_pattern_match DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // every active '*' position also reaches the next one; ascending order cascades runs
    function automatic wpm_pkg::pos_set_t close_stars(wpm_pkg::pos_set_t s);
        for (int i = 0; i < pat_len; i++)
        begin
            if (s[i] && pat_bytes[i] == wpm_pkg::SYM_STAR)
                s[i+1] = 1'b1;
        end
        return s;
    endfunction

    function automatic match_result_t step_matcher(wpm_pkg::kind_t k, logic [7:0] b);
        match_result_t     res;
        wpm_pkg::pos_set_t nxt;
        res = '{matched: 1'b0, status: 1'b0};
        case (k)
            wpm_pkg::KIND_CLEAR:
            begin
                pat_len = 0;
                reach   = '0;
            end
            wpm_pkg::KIND_APPEND:
            begin
                reach = '0;
                if (pat_len < wpm_pkg::PAT_MAX)
                begin
                    pat_bytes[pat_len] = b;
                    pat_len++;
                end
                else
                    res.status = 1'b1;
            end
            wpm_pkg::KIND_START:
            begin
                reach    = '0;
                reach[0] = 1'b1;
                reach    = close_stars(reach);
                res.matched = reach[pat_len];
            end
            default:
            begin
                nxt = '0;
                for (int i = 0; i < pat_len; i++)
                begin
                    if (reach[i])
                    begin
                        if (pat_bytes[i] == wpm_pkg::SYM_STAR)
                        begin
                            nxt[i]   = 1'b1;
                            nxt[i+1] = 1'b1;
                        end
                        else if (pat_bytes[i] == wpm_pkg::SYM_ANY || pat_bytes[i] == b)
                            nxt[i+1] = 1'b1;
                    end
                end
                reach = close_stars(nxt);
                res.matched = reach[pat_len];
            end
        endcase
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 4))
            0: return CH_A;
            1: return CH_B;
            2: return wpm_pkg::SYM_STAR;
            3: return wpm_pkg::SYM_ANY;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input wpm_pkg::kind_t k, input logic [7:0] b,
                             input logic typed, input match_result_t typed_res);
        int unsigned   gap;
        match_result_t pred;
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        kind       <= k;
        data_byte  <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pred = step_matcher(k, b);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    // clear, load a pattern, then stream texts built to fit it, some of them spoiled
    task automatic run_sequence(input int unsigned pat_target);
        logic [7:0]  pat_q [$];
        logic [7:0]  text_q [$];
        logic [7:0]  sym;
        int unsigned texts;
        int unsigned cut;
        bit          edit_mid;
        quiet    = ($urandom_range(0, 7) == 0);
        edit_mid = ($urandom_range(0, 9) == 0);
        send_beat(wpm_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        for (int i = 0; i < pat_target; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: sym = ($urandom_range(0, 1) != 0) ? CH_A : CH_B;
                5, 6, 7:       sym = wpm_pkg::SYM_STAR;
                8, 9, 10:      sym = wpm_pkg::SYM_ANY;
                default:       sym = 8'($urandom_range(0, 255));
            endcase
            send_beat(wpm_pkg::KIND_APPEND, sym, 1'b0, '0);
            if (i < wpm_pkg::PAT_MAX)
                pat_q.push_back(sym);
        end
        texts = $urandom_range(1, 3);
        for (int t = 0; t < texts; t++)
        begin
            text_q.delete();
            foreach (pat_q[j])
            begin
                if (pat_q[j] == wpm_pkg::SYM_STAR)
                    repeat ($urandom_range(0, 3)) text_q.push_back(filler_byte());
                else if (pat_q[j] == wpm_pkg::SYM_ANY)
                    text_q.push_back(8'($urandom_range(0, 255)));
                else
                    text_q.push_back(pat_q[j]);
            end
            if (text_q.size() != 0 && $urandom_range(0, 9) < 3)
            begin
                cut = $urandom_range(0, text_q.size() - 1);
                text_q[cut] = text_q[cut] ^ 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 9) < 2)
                repeat ($urandom_range(1, 3)) text_q.push_back(filler_byte());
            cut = (edit_mid && t == texts - 1) ? $urandom_range(0, text_q.size())
                                               : text_q.size() + 1;
            send_beat(wpm_pkg::KIND_START, 8'($urandom_range(0, 255)), 1'b0, '0);
            for (int j = 0; j <= text_q.size(); j++)
            begin
                // pattern edit in the middle of a text kills the rest of it
                if (j == cut)
                    send_beat(($urandom_range(0, 1) != 0) ? wpm_pkg::KIND_APPEND
                                                          : wpm_pkg::KIND_CLEAR,
                              8'($urandom_range(0, 255)), 1'b0, '0);
                if (j < text_q.size())
                    send_beat(wpm_pkg::KIND_TEXT, text_q[j], 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        int unsigned r;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        kind       = wpm_pkg::KIND_CLEAR;
        data_byte  = 8'h00;
        quiet      = 1'b0;
        pat_len    = 0;
        reach      = '0;
        directed_rows = '{
            // byte with no text started
            '{wpm_pkg::KIND_TEXT,   CH_A,              1'b1, '{1'b0, 1'b0}},
            // empty pattern, empty text
            '{wpm_pkg::KIND_START,  8'h00,             1'b1, '{1'b1, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h00,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_CLEAR,  8'hFF,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_APPEND, wpm_pkg::SYM_STAR, 1'b1, '{1'b0, 1'b0}},
            // lone star takes the empty run
            '{wpm_pkg::KIND_START,  8'hFF,             1'b1, '{1'b1, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b1, '{1'b1, 1'b0}},
            // edit during a text
            '{wpm_pkg::KIND_APPEND, 8'h00,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h00,             1'b1, '{1'b0, 1'b0}},
            // zero byte is a literal
            '{wpm_pkg::KIND_START,  8'h00,             1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h00,             1'b0, '{1'b0, 1'b0}},
            // star is plain in the text
            '{wpm_pkg::KIND_TEXT,   wpm_pkg::SYM_STAR, 1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h00,             1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_CLEAR,  8'h00,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_APPEND, wpm_pkg::SYM_ANY,  1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_APPEND, 8'hFF,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_START,  8'h00,             1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   wpm_pkg::SYM_ANY,  1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b0, '{1'b0, 1'b0}},
            // text runs past the pattern
            '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h80,             1'b0, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_APPEND, 8'h7F,             1'b1, '{1'b0, 1'b0}},
            '{wpm_pkg::KIND_TEXT,   8'h7F,             1'b1, '{1'b0, 1'b0}}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].kind_val, directed_rows[i].byte_val,
                      directed_rows[i].typed, directed_rows[i].res);

        // first random sequence overfills the pattern
        run_sequence(wpm_pkg::PAT_MAX + 2);
        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                quiet = 1'b0;
                repeat ($urandom_range(5, 15))
                    send_beat(wpm_pkg::kind_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)), 1'b0, '0);
            end
            else if (r < 80)
                run_sequence($urandom_range(0, 8));
            else if (r < 95)
                run_sequence($urandom_range(9, wpm_pkg::PAT_MAX - 1));
            else
                run_sequence($urandom_range(wpm_pkg::PAT_MAX, wpm_pkg::PAT_MAX + 3));
        end

        @(negedge clk);
        item_valid <= 1'b0;
        quiet = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked", items_sent, results_checked);
        $display("%0d results matched, %0d appends dropped on a full pattern",
                 match_count, drop_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result-side back-pressure
    initial
    begin
        int unsigned run_len;
        result_stall = 1'b0;
        forever
        begin
            if (quiet)
            begin
                @(negedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                run_len = pick_gap();
                if (run_len != 0)
                begin
                    @(negedge clk);
                    result_stall <= 1'b1;
                    repeat (run_len - 1) @(negedge clk);
                end
                @(negedge clk);
                result_stall <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: matched=%0b status=%0b",
                       matched, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (matched !== want.matched)
                begin
                    $error("matched: expected %0b, got %0b", want.matched, matched);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, status);
                    error_count++;
                end
                results_checked++;
                if (want.matched)
                    match_count++;
                if (want.status)
                    drop_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule
